// ----- sv/sliding_window_peak_picker_defines.svh -----
// Assertion macros for the sliding window peak picker RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef SLIDING_WINDOW_PEAK_PICKER_DEFINES_SVH
`define SLIDING_WINDOW_PEAK_PICKER_DEFINES_SVH

`ifndef ASSERT_OFF

// condition must hold at every clock edge out of reset
`define SWPP_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("swpp assertion failed");

// antecedent implies consequent in the same cycle
`define SWPP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swpp assertion failed");

// antecedent implies consequent in the cycle after
`define SWPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swpp assertion failed");

`else

`define SWPP_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define SWPP_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define SWPP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- sv/swpp_pkg.sv -----
// Shared types and constants for the sliding window peak picker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package swpp_pkg;

   // default sizing of the block
   localparam int DEF_MAX_WINDOW     = 63;
   localparam int DEF_MAX_SIGNAL     = 65536;
   localparam int DEF_MAX_PEAK_COUNT = 1024;
   localparam int DEF_SAMPLE_WIDTH   = 16;

   // fixed field widths
   localparam int SIG_LEN_W = 17;
   localparam int WIN_LEN_W = 6;
   localparam int LOC_W     = 17;
   localparam int CNT_W     = 11;

   // configuration registers
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_SIGNAL_LENGTH = 1'b0;
   localparam logic CSR_WINDOW_LENGTH = 1'b1;
   localparam logic [SIG_LEN_W-1:0] SIG_LEN_RESET = SIG_LEN_W'(1024);
   localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = WIN_LEN_W'(5);

   // result kinds
   localparam logic KIND_PEAK  = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // per-request summary passed from front to back
   typedef struct packed {
      logic             check;      // full window present
      logic             above;      // centre strictly above its threshold
      logic             frame_end;  // last request of the frame
      logic [LOC_W-1:0] loc;        // 1-based location of the centre
   } item_type;

endpackage

// ----- sv/swpp_front.sv -----
// Front end: window delay lines, frame index and the parallel window compare.
// Depends on swpp_pkg; feeds swpp_fifo.
`timescale 1ns / 1ps

module swpp_front #(
   parameter int MAX_WINDOW   = swpp_pkg::DEF_MAX_WINDOW,
   parameter int MAX_SIGNAL   = swpp_pkg::DEF_MAX_SIGNAL,
   parameter int SAMPLE_WIDTH = swpp_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [swpp_pkg::SIG_LEN_W-1:0]  signal_length,
   input  logic [swpp_pkg::WIN_LEN_W-1:0]  window_length,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]  in_sample,
   input  logic signed [SAMPLE_WIDTH-1:0]  in_threshold,
   input  logic                            q_ready,
   output logic                            q_push,
   output swpp_pkg::item_type              q_item,
   output logic [MAX_WINDOW-1:0]           q_greater
);

   localparam int HALF    = MAX_WINDOW / 2 + 1;
   localparam int MIDW    = $clog2(HALF);
   localparam int WINW    = $clog2(MAX_WINDOW + 1);
   localparam int CW      = (WINW > swpp_pkg::WIN_LEN_W) ? WINW : swpp_pkg::WIN_LEN_W;
   localparam int MAX_ODD = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;
   localparam int IDXW    = $clog2(MAX_SIGNAL + 1);
   localparam int LENW    = ((IDXW > swpp_pkg::SIG_LEN_W) ? IDXW : swpp_pkg::SIG_LEN_W) + 1;
   localparam int CMPW    = ((IDXW > CW) ? IDXW : CW) + 1;

   logic signed [SAMPLE_WIDTH-1:0] swin_ff [MAX_WINDOW];
   logic signed [SAMPLE_WIDTH-1:0] swin_in [MAX_WINDOW];
   logic signed [SAMPLE_WIDTH-1:0] thr_ff  [HALF];
   logic signed [SAMPLE_WIDTH-1:0] thr_in  [HALF];
   logic signed [SAMPLE_WIDTH-1:0] cand    [HALF];
   logic [IDXW-1:0]                idx_ff;
   logic [IDXW-1:0]                idx_in;

   logic [CW-1:0]                  w_raw;
   logic [CW-1:0]                  eff_w;
   logic [CW-1:0]                  mid_full;
   logic [MIDW-1:0]                mid;
   logic [LENW-1:0]                len_raw;
   logic [LENW-1:0]                eff_len;
   logic [LENW-1:0]                idx_next;
   logic [CMPW-1:0]                loc_w;
   logic [CMPW+swpp_pkg::LOC_W-1:0] loc_ext;
   logic signed [SAMPLE_WIDTH-1:0] centre;
   logic signed [SAMPLE_WIDTH-1:0] centre_thr;
   logic                           frame_end;
   logic                           take;

   assign in_ready = q_ready;
   assign take     = in_valid & q_ready;
   assign q_push   = take;

   // effective window size and its centre tap
   always_comb begin
      w_raw    = CW'(window_length) | CW'(1);
      eff_w    = (w_raw > CW'(MAX_ODD)) ? CW'(MAX_ODD) : w_raw;
      mid_full = eff_w >> 1;
      mid      = mid_full[MIDW-1:0];
   end

   // effective frame length and end of frame
   always_comb begin
      len_raw = LENW'(signal_length);
      if (len_raw == '0) begin
         eff_len = LENW'(1);
      end else if (len_raw > LENW'(MAX_SIGNAL)) begin
         eff_len = LENW'(MAX_SIGNAL);
      end else begin
         eff_len = len_raw;
      end
      idx_next  = LENW'(idx_ff) + LENW'(1);
      frame_end = (idx_next >= eff_len);
      idx_in    = frame_end ? '0 : idx_next[IDXW-1:0];
   end

   // delay lines after the shift of this request
   always_comb begin
      swin_in[0] = in_sample;
      for (int i = 1; i < MAX_WINDOW; i++) begin
         swin_in[i] = swin_ff[i-1];
      end
      thr_in[0] = in_threshold;
      for (int i = 1; i < HALF; i++) begin
         thr_in[i] = thr_ff[i-1];
      end
      for (int i = 0; i < HALF; i++) begin
         cand[i] = swin_in[i];
      end
   end

   assign centre     = cand[mid];
   assign centre_thr = thr_in[mid];

   // parallel compare against the centre, masked to the active window
   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         q_greater[i] = (swin_in[i] > centre) && (CW'(i) < eff_w) && (CW'(i) != mid_full);
      end
   end

   // request summary
   always_comb begin
      loc_w            = CMPW'(idx_ff) - CMPW'(mid_full) + CMPW'(1);
      loc_ext          = {{swpp_pkg::LOC_W{1'b0}}, loc_w};
      q_item.check     = (CMPW'(idx_ff) >= (CMPW'(eff_w) - CMPW'(1)));
      q_item.above     = (centre > centre_thr);
      q_item.frame_end = frame_end;
      q_item.loc       = loc_ext[swpp_pkg::LOC_W-1:0];
   end

   // window and index registers, cleared at reset and at each frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         for (int i = 0; i < MAX_WINDOW; i++) swin_ff[i] <= '0;
         for (int i = 0; i < HALF; i++) thr_ff[i] <= '0;
      end else if (take) begin
         idx_ff <= idx_in;
         for (int i = 0; i < MAX_WINDOW; i++) begin
            swin_ff[i] <= frame_end ? '0 : swin_in[i];
         end
         for (int i = 0; i < HALF; i++) begin
            thr_ff[i] <= frame_end ? '0 : thr_in[i];
         end
      end
   end

endmodule

// ----- sv/swpp_fifo.sv -----
// Short queue of request summaries between the front and back ends.
// Depends on swpp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sliding_window_peak_picker_defines.svh"

module swpp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = swpp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_pop,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CNW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CNW-1:0]   count_ff;
   logic [CNW-1:0]   count_in;
   logic             push;
   logic             pop;

   assign wr_ready = (count_ff != CNW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid & wr_ready;
   assign pop      = rd_pop & rd_valid;

   // occupancy
   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + CNW'(1);
         2'b01:   count_in = count_ff - CNW'(1);
         default: count_in = count_ff;
      endcase
   end

   // pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PW'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + PW'(1);
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wr_data;
   end

   `SWPP_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNW'(DEPTH))
   `SWPP_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + CNW'(1))
   `SWPP_ASSERT_ALWAYS(a_ptr_gap, clock, reset, PW'(wr_ptr_ff - rd_ptr_ff) == count_ff[PW-1:0])

endmodule

// ----- sv/swpp_back.sv -----
// Back end: window reduction, peak limit, frame count and result register.
// Depends on swpp_pkg; takes request summaries from swpp_fifo.
`timescale 1ns / 1ps
`include "sliding_window_peak_picker_defines.svh"

module swpp_back #(
   parameter int MAX_WINDOW     = swpp_pkg::DEF_MAX_WINDOW,
   parameter int MAX_PEAK_COUNT = swpp_pkg::DEF_MAX_PEAK_COUNT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  swpp_pkg::item_type           head_item,
   input  logic [MAX_WINDOW-1:0]        head_greater,
   output logic                         head_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_kind,
   output logic [swpp_pkg::LOC_W-1:0]   rsp_location,
   output logic [swpp_pkg::CNT_W-1:0]   rsp_count,
   output logic                         rsp_last
);

   localparam int PCW = $clog2(MAX_PEAK_COUNT + 1);

   logic [PCW-1:0]                 peaks_ff;
   logic [PCW-1:0]                 peaks_in;
   logic                           peak_done_ff;
   logic                           peak_done_in;
   logic                           valid_ff;
   logic                           valid_in;
   logic                           kind_ff;
   logic [swpp_pkg::LOC_W-1:0]     loc_ff;
   logic [swpp_pkg::CNT_W-1:0]     cnt_ff;
   logic                           load_peak;
   logic                           load_count;
   logic                           is_peak;
   logic                           can_load;
   logic [PCW+swpp_pkg::CNT_W-1:0] cnt_ext;

   assign rsp_valid    = valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_location = loc_ff;
   assign rsp_count    = cnt_ff;
   assign rsp_last     = (kind_ff == swpp_pkg::KIND_COUNT);

   assign can_load = !valid_ff || rsp_ready;
   assign cnt_ext  = {{swpp_pkg::CNT_W{1'b0}}, peaks_ff};

   // peak decision for the request at the head of the queue
   assign is_peak = head_item.check && head_item.above && !(|head_greater) &&
                    (peaks_ff < PCW'(MAX_PEAK_COUNT));

   // result sequencing: peak first, then the frame count
   always_comb begin
      load_peak    = 1'b0;
      load_count   = 1'b0;
      head_pop     = 1'b0;
      peaks_in     = peaks_ff;
      peak_done_in = peak_done_ff;
      valid_in     = valid_ff && !rsp_ready;
      if (head_valid) begin
         if (is_peak && !peak_done_ff) begin
            if (can_load) begin
               load_peak = 1'b1;
               valid_in  = 1'b1;
               peaks_in  = peaks_ff + PCW'(1);
               if (head_item.frame_end) begin
                  peak_done_in = 1'b1;
               end else begin
                  head_pop = 1'b1;
               end
            end
         end else if (head_item.frame_end) begin
            if (can_load) begin
               load_count   = 1'b1;
               valid_in     = 1'b1;
               head_pop     = 1'b1;
               peaks_in     = '0;
               peak_done_in = 1'b0;
            end
         end else begin
            head_pop     = 1'b1;
            peak_done_in = 1'b0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         peaks_ff     <= '0;
         peak_done_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         peaks_ff     <= peaks_in;
         peak_done_ff <= peak_done_in;
         valid_ff     <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load_peak) begin
         kind_ff <= swpp_pkg::KIND_PEAK;
         loc_ff  <= head_item.loc;
         cnt_ff  <= '0;
      end else if (load_count) begin
         kind_ff <= swpp_pkg::KIND_COUNT;
         loc_ff  <= '0;
         cnt_ff  <= cnt_ext[swpp_pkg::CNT_W-1:0];
      end
   end

   `SWPP_ASSERT_ALWAYS(a_peak_limit, clock, reset, peaks_ff <= PCW'(MAX_PEAK_COUNT))
   `SWPP_ASSERT_IMPL(a_done_has_head, clock, reset, peak_done_ff, head_valid && head_item.frame_end)
   `SWPP_ASSERT_NEXT(a_count_clears, clock, reset, load_count, peaks_ff == '0)

endmodule

// ----- sv/sliding_window_peak_picker.sv -----
// Sliding window peak picker: streaming local-maximum peak detector.
// Request channel req_*: one correlation sample and its threshold per request.
// Response channel rsp_*: peak location results (tuser 0) and, at the end of
// each frame, one peak count result (tuser 1) marked with tlast.
// csr_*: register 0 signal_length at 0x0, register 1 window_length at 0x4.
// Throughput: one request per cycle while the queue has room; a request that
// yields both a peak and the frame count stays at the head of the four-entry
// queue between the compare stage and the result stage until both results
// are loaded. The queue absorbs occasional ones; a steady run lowers the rate.
// A taken request is written into the queue, then decided at its head and its
// result registered in the result register; a count follows its request's peak.
// The window compare of all taps runs in the cycle the request is taken.
// Reset: synchronous; clears the delay lines, frame index, peak count, queue
// and result valid flag, and loads signal_length 1024 and window_length 5.
// Back-pressure: while rsp_tready is low the result register holds; requests
// keep flowing into the queue until it fills, then req_tready drops.
// Depends on swpp_pkg, swpp_front, swpp_fifo, swpp_back.
`timescale 1ns / 1ps

module sliding_window_peak_picker #(
   parameter int MAX_WINDOW     = swpp_pkg::DEF_MAX_WINDOW,
   parameter int MAX_SIGNAL     = swpp_pkg::DEF_MAX_SIGNAL,
   parameter int MAX_PEAK_COUNT = swpp_pkg::DEF_MAX_PEAK_COUNT,
   parameter int SAMPLE_WIDTH   = swpp_pkg::DEF_SAMPLE_WIDTH,
   localparam int REQ_W         = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_W-1:0]                  req_tdata,  // sample, threshold
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // peak_location, peak_count
   output logic                              rsp_tuser,  // result_kind
   output logic                              rsp_tlast,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [swpp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [swpp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [swpp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int ITEM_W = $bits(swpp_pkg::item_type);
   localparam int Q_W    = ITEM_W + MAX_WINDOW;
   localparam int PAD_W  = 32 - swpp_pkg::LOC_W - swpp_pkg::CNT_W;

   logic [swpp_pkg::SIG_LEN_W-1:0] sig_len_ff;
   logic [swpp_pkg::WIN_LEN_W-1:0] win_len_ff;
   logic                           csr_wr;
   logic                           csr_sel;

   logic                           q_ready;
   logic                           q_push;
   swpp_pkg::item_type             q_item;
   logic [MAX_WINDOW-1:0]          q_greater;
   logic                           head_valid;
   logic                           head_pop;
   logic [Q_W-1:0]                 head_data;
   swpp_pkg::item_type             head_item;
   logic [MAX_WINDOW-1:0]          head_greater;

   logic                           rsp_kind;
   logic [swpp_pkg::LOC_W-1:0]     rsp_location;
   logic [swpp_pkg::CNT_W-1:0]     rsp_count;

   // register port
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_len_ff <= swpp_pkg::SIG_LEN_RESET;
         win_len_ff <= swpp_pkg::WIN_LEN_RESET;
      end else if (csr_wr) begin
         unique case (csr_sel)
            swpp_pkg::CSR_SIGNAL_LENGTH: sig_len_ff <= csr_pwdata[swpp_pkg::SIG_LEN_W-1:0];
            swpp_pkg::CSR_WINDOW_LENGTH: win_len_ff <= csr_pwdata[swpp_pkg::WIN_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         swpp_pkg::CSR_SIGNAL_LENGTH: csr_prdata = swpp_pkg::CSR_DATA_W'(sig_len_ff);
         swpp_pkg::CSR_WINDOW_LENGTH: csr_prdata = swpp_pkg::CSR_DATA_W'(win_len_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // front end: delay lines and window compare
   swpp_front #(
      .MAX_WINDOW   (MAX_WINDOW),
      .MAX_SIGNAL   (MAX_SIGNAL),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .signal_length (sig_len_ff),
      .window_length (win_len_ff),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_sample     (req_tdata[SAMPLE_WIDTH-1:0]),
      .in_threshold  (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .q_ready       (q_ready),
      .q_push        (q_push),
      .q_item        (q_item),
      .q_greater     (q_greater)
   );

   // queue between front and back
   swpp_fifo #(
      .WIDTH (Q_W),
      .DEPTH (swpp_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_push),
      .wr_ready (q_ready),
      .wr_data  ({q_item, q_greater}),
      .rd_valid (head_valid),
      .rd_pop   (head_pop),
      .rd_data  (head_data)
   );

   assign head_item    = swpp_pkg::item_type'(head_data[Q_W-1:MAX_WINDOW]);
   assign head_greater = head_data[MAX_WINDOW-1:0];

   // back end: peak decision and results
   swpp_back #(
      .MAX_WINDOW     (MAX_WINDOW),
      .MAX_PEAK_COUNT (MAX_PEAK_COUNT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_item    (head_item),
      .head_greater (head_greater),
      .head_pop     (head_pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_kind     (rsp_kind),
      .rsp_location (rsp_location),
      .rsp_count    (rsp_count),
      .rsp_last     (rsp_tlast)
   );

   // response packing
   assign rsp_tuser = rsp_kind;
   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_count, rsp_location};

endmodule
